### src/mfm_pkg.sv
// Shared types and constants for the 4x4 float matrix multiply.
package mfm_pkg;

    localparam int STORE_DEPTH = 16;
    localparam int MAX_EMIT    = 16;
    localparam int CNT_W       = 5;

    localparam logic [1:0]  OP_LOAD_LEFT  = 2'd0;
    localparam logic [1:0]  OP_LOAD_RIGHT = 2'd1;
    localparam logic [1:0]  OP_COMPUTE    = 2'd2;

    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
    localparam logic [31:0] POS_ZERO  = 32'h0000_0000;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  element_index;
        logic [31:0] element_value;
    } cmd_t;

    typedef struct packed {
        logic [3:0]  result_index;
        logic [31:0] result_value;
        logic        last_result;
    } res_t;

    typedef enum logic {
        FPU_MUL,
        FPU_ADD
    } fpu_op_t;

    typedef struct packed {
        logic        valid;
        fpu_op_t     op;
        logic [31:0] a;
        logic [31:0] b;
    } fpu_req_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] value;
    } fpu_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_MUL_WAIT,
        ST_ADD,
        ST_ADD_WAIT,
        ST_EMIT
    } state_t;

endpackage

### src/matrix4_float_multiply.sv
// Top level of the single-precision square matrix multiply.
//
// Usage: one command beat is taken at a clock edge where start is high and
// busy is low. A load-left or load-right beat writes one element (index
// row*MATRIX_DIM+column) in that same cycle and busy stays low; an index
// beyond the matrix is dropped. A compute beat raises busy and the block
// walks the product in index order, one element at a time. Each element
// is four multiply-then-add steps through a single shared pipelined float
// unit, each multiply and add waiting for its result, then an emit step.
// Each result beat sits on result for exactly one cycle with strobe high;
// the receiver cannot stall, so nothing backs up. last_result marks the
// sixteenth beat, after which busy drops in the next cycle.
// Unused command codes are taken and ignored.
// Reset clears both element stores to +0.0 and returns the sequencer to
// idle; any compute in flight is abandoned.
module matrix4_float_multiply #(
    parameter int MATRIX_DIM = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  mfm_pkg::cmd_t command,
    output logic          strobe,
    output mfm_pkg::res_t result
);
    import mfm_pkg::*;

    localparam int ELEMS      = MATRIX_DIM * MATRIX_DIM;
    localparam int EMIT_COUNT = (ELEMS < MAX_EMIT) ? ELEMS : MAX_EMIT;
    localparam int CW         = $clog2(MATRIX_DIM);
    localparam int IXW        = $clog2(ELEMS + STORE_DEPTH) + 1;

    // element stores, reset to +0.0
    logic [31:0] left_store_reg  [STORE_DEPTH];
    logic [31:0] right_store_reg [STORE_DEPTH];

    state_t              state_reg, state_next;
    logic [CW-1:0]       j_reg, j_next;
    logic [CW-1:0]       row_reg, row_next;
    logic [CW-1:0]       col_reg, col_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [31:0]         acc_reg, acc_next;
    logic [31:0]         prod_reg, prod_next;

    logic                accept;
    logic                load_ok;
    logic                last_j, last_col, last_n;
    logic [IXW-1:0]      r_idx, l_idx;
    logic [31:0]         v_elem, u_elem;
    fpu_req_t            fpu_req;
    fpu_rsp_t            fpu_rsp;

    assign accept  = start && (state_reg == ST_IDLE);
    assign load_ok = ({28'd0, command.element_index} < 32'(ELEMS));
    assign last_j   = (j_reg == CW'(MATRIX_DIM - 1));
    assign last_col = (col_reg == CW'(MATRIX_DIM - 1));
    assign last_n   = (n_reg == CNT_W'(EMIT_COUNT - 1));

    // V(row,j) from the right store, U(j,col) from the left store; entries
    // past the store depth are never loadable and read as zero
    assign r_idx  = IXW'(row_reg) * IXW'(MATRIX_DIM) + IXW'(j_reg);
    assign l_idx  = IXW'(j_reg) * IXW'(MATRIX_DIM) + IXW'(col_reg);
    assign v_elem = (r_idx < IXW'(STORE_DEPTH)) ? right_store_reg[r_idx[3:0]] : POS_ZERO;
    assign u_elem = (l_idx < IXW'(STORE_DEPTH)) ? left_store_reg[l_idx[3:0]] : POS_ZERO;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                left_store_reg[i]  <= POS_ZERO;
                right_store_reg[i] <= POS_ZERO;
            end
        end
        else if (accept && load_ok)
        begin
            if (command.operation == OP_LOAD_LEFT)
                left_store_reg[command.element_index] <= command.element_value;
            else if (command.operation == OP_LOAD_RIGHT)
                right_store_reg[command.element_index] <= command.element_value;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept && (command.operation == OP_COMPUTE))
                    state_next = ST_MUL;
            ST_MUL:
                state_next = ST_MUL_WAIT;
            ST_MUL_WAIT:
                if (fpu_rsp.valid)
                    state_next = ST_ADD;
            ST_ADD:
                state_next = ST_ADD_WAIT;
            ST_ADD_WAIT:
                if (fpu_rsp.valid)
                    state_next = last_j ? ST_EMIT : ST_MUL;
            ST_EMIT:
                state_next = last_n ? ST_IDLE : ST_MUL;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        j_next    = j_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        n_next    = n_reg;
        acc_next  = acc_reg;
        prod_next = prod_reg;
        fpu_req.valid = 1'b0;
        fpu_req.op    = FPU_MUL;
        fpu_req.a     = u_elem;
        fpu_req.b     = v_elem;
        unique case (state_reg)
            ST_IDLE:
            begin
                j_next   = '0;
                row_next = '0;
                col_next = '0;
                n_next   = '0;
                acc_next = POS_ZERO;
            end
            ST_MUL:
                fpu_req.valid = 1'b1;
            ST_MUL_WAIT:
                if (fpu_rsp.valid)
                    prod_next = fpu_rsp.value;
            ST_ADD:
            begin
                fpu_req.valid = 1'b1;
                fpu_req.op    = FPU_ADD;
                fpu_req.a     = acc_reg;
                fpu_req.b     = prod_reg;
            end
            ST_ADD_WAIT:
                if (fpu_rsp.valid)
                begin
                    acc_next = fpu_rsp.value;
                    if (!last_j)
                        j_next = j_reg + 1'b1;
                end
            ST_EMIT:
            begin
                acc_next = POS_ZERO;
                j_next   = '0;
                n_next   = n_reg + 1'b1;
                if (last_col)
                begin
                    col_next = '0;
                    row_next = row_reg + 1'b1;
                end
                else
                    col_next = col_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            j_reg     <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            j_reg     <= j_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            n_reg     <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
    end

    mfm_fpu u_fpu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (fpu_req),
        .rsp   (fpu_rsp)
    );

    assign busy                = (state_reg != ST_IDLE);
    assign strobe              = (state_reg == ST_EMIT);
    assign result.result_index = n_reg[3:0];
    assign result.result_value = acc_reg;
    assign result.last_result  = last_n;

    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("result beat outside a compute");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.last_result |=> !busy)
        else $error("busy held after final beat");

    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start) && ($past(command.operation) == OP_COMPUTE))
        else $error("busy rose without a compute beat");

endmodule

### src/mfm_fpu.sv
// Shared single-precision multiply/add unit, three-stage, round to nearest even.
module mfm_fpu (
    input  logic              clk,
    input  logic              rst_n,
    input  mfm_pkg::fpu_req_t req,
    output mfm_pkg::fpu_rsp_t rsp
);
    import mfm_pkg::*;

    // operand decode
    logic        sa, sb;
    logic [7:0]  ea, eb, eae, ebe;
    logic [22:0] fa, fb;
    logic [23:0] ma, mb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

    // stage 1
    logic               s1_valid_reg, s1_valid_next;
    logic               s1_spec_reg, s1_spec_next;
    logic [31:0]        s1_sval_reg, s1_sval_next;
    logic               s1_sign_reg, s1_sign_next;
    logic               s1_zsign_reg, s1_zsign_next;
    logic [47:0]        s1_m_reg, s1_m_next;
    logic signed [11:0] s1_e_reg, s1_e_next;

    // stage 2
    logic               s2_valid_reg;
    logic               s2_spec_reg;
    logic [31:0]        s2_sval_reg;
    logic               s2_sign_reg;
    logic               s2_zsign_reg;
    logic [47:0]        s2_m_reg;
    logic signed [11:0] s2_e_reg;
    logic [5:0]         s2_l_reg, s2_l_next;
    logic               s2_zero_reg;

    // stage 3
    logic               s3_valid_reg;
    logic [31:0]        s3_val_reg, s3_val_next;

    // add path
    logic        a_big, sgn_big, sgn_small;
    logic [7:0]  e_big, e_small, d;
    logic [23:0] m_big, m_small;
    logic [53:0] al;
    logic [26:0] big_x, small_x;
    logic [27:0] sum_m;

    // round path
    logic signed [11:0] s_amt, s_a, s_b, fld;
    logic [111:0]       ext;
    logic [6:0]         sr;
    logic [47:0]        q;
    logic               g, st, rnd;
    logic [24:0]        qr;
    logic [33:0]        packed_sum;

    always_comb
    begin
        sa = req.a[31]; ea = req.a[30:23]; fa = req.a[22:0];
        sb = req.b[31]; eb = req.b[30:23]; fb = req.b[22:0];
        a_nan  = (ea == 8'hFF) && (fa != 23'd0);
        b_nan  = (eb == 8'hFF) && (fb != 23'd0);
        a_inf  = (ea == 8'hFF) && (fa == 23'd0);
        b_inf  = (eb == 8'hFF) && (fb == 23'd0);
        a_zero = (ea == 8'd0) && (fa == 23'd0);
        b_zero = (eb == 8'd0) && (fb == 23'd0);
        ma  = {ea != 8'd0, fa};
        mb  = {eb != 8'd0, fb};
        eae = (ea == 8'd0) ? 8'd1 : ea;
        ebe = (eb == 8'd0) ? 8'd1 : eb;

        // larger magnitude first so the subtraction never goes negative
        a_big     = req.a[30:0] >= req.b[30:0];
        e_big     = a_big ? eae : ebe;
        e_small   = a_big ? ebe : eae;
        m_big     = a_big ? ma : mb;
        m_small   = a_big ? mb : ma;
        sgn_big   = a_big ? sa : sb;
        sgn_small = a_big ? sb : sa;
        d         = e_big - e_small;
        al        = {m_small, 3'b000, 27'd0} >> ((d > 8'd27) ? 8'd27 : d);
        big_x     = {m_big, 3'b000};
        small_x   = {al[53:28], al[27] | (|al[26:0])};
        if (sgn_big == sgn_small)
            sum_m = {1'b0, big_x} + {1'b0, small_x};
        else
            sum_m = {1'b0, big_x} - {1'b0, small_x};

        s1_valid_next = req.valid;
        s1_spec_next  = 1'b0;
        s1_sval_next  = CANON_NAN;
        if (req.op == FPU_MUL)
        begin
            s1_sign_next  = sa ^ sb;
            s1_zsign_next = sa ^ sb;
            s1_m_next     = 48'(ma) * 48'(mb);
            s1_e_next     = $signed({4'd0, eae}) + $signed({4'd0, ebe}) - 12'sd300;
            if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf))
                s1_spec_next = 1'b1;
            else if (a_inf || b_inf)
            begin
                s1_spec_next = 1'b1;
                s1_sval_next = {sa ^ sb, 8'hFF, 23'd0};
            end
        end
        else
        begin
            s1_sign_next  = sgn_big;
            s1_zsign_next = sa & sb;
            s1_m_next     = {20'd0, sum_m};
            s1_e_next     = $signed({4'd0, e_big}) - 12'sd153;
            if (a_nan || b_nan || (a_inf && b_inf && (sa != sb)))
                s1_spec_next = 1'b1;
            else if (a_inf)
            begin
                s1_spec_next = 1'b1;
                s1_sval_next = req.a;
            end
            else if (b_inf)
            begin
                s1_spec_next = 1'b1;
                s1_sval_next = req.b;
            end
        end
    end

    // leading-one position
    always_comb
    begin
        s2_l_next = 6'd0;
        for (int i = 0; i < 48; i++)
        begin
            if (s1_m_reg[i])
                s2_l_next = 6'(i);
        end
    end

    // align to the target lsb, round, pack
    always_comb
    begin
        s_a   = $signed({6'd0, s2_l_reg}) - 12'sd23;
        s_b   = -12'sd149 - s2_e_reg;
        s_amt = (s_a > s_b) ? s_a : s_b;
        sr    = (s_amt > 12'sd111) ? 7'd111 : s_amt[6:0];
        ext   = {s2_m_reg, 64'd0} >> sr;
        if (s_amt < 12'sd0)
        begin
            q  = s2_m_reg << (-s_amt);
            g  = 1'b0;
            st = 1'b0;
        end
        else
        begin
            q  = ext[111:64];
            g  = ext[63];
            st = |ext[62:0];
        end
        rnd        = g & (st | q[0]);
        qr         = q[24:0] + {24'd0, rnd};
        fld        = s_amt + s2_e_reg + 12'sd149;
        packed_sum = {1'b0, fld[9:0], 23'd0} + {9'd0, qr};
        if (s2_spec_reg)
            s3_val_next = s2_sval_reg;
        else if (s2_zero_reg)
            s3_val_next = {s2_zsign_reg, 31'd0};
        else if (packed_sum >= 34'h0_7F80_0000)
            s3_val_next = {s2_sign_reg, 8'hFF, 23'd0};
        else
            s3_val_next = {s2_sign_reg, packed_sum[30:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_spec_reg  <= s1_spec_next;
        s1_sval_reg  <= s1_sval_next;
        s1_sign_reg  <= s1_sign_next;
        s1_zsign_reg <= s1_zsign_next;
        s1_m_reg     <= s1_m_next;
        s1_e_reg     <= s1_e_next;
        s2_spec_reg  <= s1_spec_reg;
        s2_sval_reg  <= s1_sval_reg;
        s2_sign_reg  <= s1_sign_reg;
        s2_zsign_reg <= s1_zsign_reg;
        s2_m_reg     <= s1_m_reg;
        s2_e_reg     <= s1_e_reg;
        s2_l_reg     <= s2_l_next;
        s2_zero_reg  <= (s1_m_reg == 48'd0);
        s3_val_reg   <= s3_val_next;
    end

    assign rsp.valid = s3_valid_reg;
    assign rsp.value = s3_val_reg;

endmodule

### bench/tb_top.sv
// Self-checking bench for the 4x4 single-precision matrix multiply.
module tb_top;
    import mfm_pkg::*;

    localparam int DIM        = 4;
    localparam int RAND_ITEMS = 400;
    localparam int STALL_MAX  = 5000;   // cycles with no beat either way
    localparam int DRAIN_CYC  = 40;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  start = 1'b0;
    logic  busy;
    cmd_t  command = '0;
    logic  strobe;
    res_t  result;

    // Commands waiting to be driven, and product beats still owed by the block.
    cmd_t  cmd_backlog[$];
    res_t  product_due[$];

    // Own copy of the two element stores.
    logic [31:0] left_mat[16];
    logic [31:0] right_mat[16];

    int unsigned total_cmds  = 0;
    int unsigned beats_taken = 0;
    int unsigned errors      = 0;
    int unsigned quiet_cyc   = 0;

    matrix4_float_multiply #(.MATRIX_DIM(DIM)) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .command (command),
        .strobe  (strobe),
        .result  (result)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Float arithmetic. A single op is done in double, which is exact for
    // a product of two singles and wide enough for a sum, then rounded
    // once to single by hand (nearest-even, gradual underflow kept).
    // ------------------------------------------------------------------
    function automatic real single_to_real(logic [31:0] f);
        logic [7:0]  e;
        logic [22:0] m;
        logic [51:0] fr;
        int          p;
        e = f[30:23];
        m = f[22:0];
        if (e == 8'hFF)
            return (m == 0) ? $bitstoreal({f[31], 11'h7FF, 52'h0})
                            : $bitstoreal(64'h7FF8_0000_0000_0000);
        if (e == 8'h00)
        begin
            if (m == 0)
                return $bitstoreal({f[31], 63'h0});
            // subnormal: normalise onto the leading one
            p = 22;
            while (!m[p])
                p--;
            fr = {m, 29'b0};
            fr = fr << (23 - p);
            return $bitstoreal({f[31], 11'(p - 149 + 1023), fr});
        end
        return $bitstoreal({f[31], 11'(int'(e) + 896), m, 29'b0});
    endfunction

    function automatic logic [31:0] real_to_single(real r);
        logic [63:0] d;
        logic [63:0] sig;
        logic [63:0] kept;
        logic [63:0] rest;
        logic [31:0] mag;
        logic        up;
        int          x;
        int          sh;
        d = $realtobits(r);
        if (d[62:52] == 11'h7FF)
            return (d[51:0] != 0) ? CANON_NAN : {d[63], 31'h7F80_0000};
        if (d[62:52] == 11'h000)
            return {d[63], 31'h0};
        x = int'({21'b0, d[62:52]}) - 1023;
        if (x > 127)
            return {d[63], 31'h7F80_0000};
        sig = {11'b1, d[51:0]};
        sh  = (x >= -126) ? 29 : 29 + (-126 - x);
        if (sh > 60)
            sh = 60;
        kept = sig >> sh;
        rest = sig & ((64'd1 << (sh - 1)) - 64'd1);
        up   = sig[sh-1] && (rest != 0 || kept[0]);
        // carry out of the mantissa rolls into the exponent, up to infinity
        mag  = (x >= -126) ? ((32'(x + 127) << 23) | 32'(kept[22:0])) : 32'(kept);
        mag  = mag + 32'(up);
        return {d[63], mag[30:0]};
    endfunction

    function automatic logic [31:0] product_entry(int row, int col);
        logic [31:0] acc;
        logic [31:0] prod;
        acc = POS_ZERO;
        for (int j = 0; j < DIM; j++)
        begin
            prod = real_to_single(single_to_real(left_mat[j*DIM + col])
                                * single_to_real(right_mat[row*DIM + j]));
            acc  = real_to_single(single_to_real(acc) + single_to_real(prod));
        end
        return acc;   // NaN already canonical from rounding
    endfunction

    // Apply one accepted command beat to the store copy and owe the products.
    task automatic apply_command(cmd_t c);
        res_t r;
        case (c.operation)
            OP_LOAD_LEFT:  left_mat[c.element_index]  = c.element_value;
            OP_LOAD_RIGHT: right_mat[c.element_index] = c.element_value;
            OP_COMPUTE:
            begin
                for (int n = 0; n < MAX_EMIT; n++)
                begin
                    r.result_index = 4'(n);
                    r.result_value = product_entry(n / DIM, n % DIM);
                    r.last_result  = (n == MAX_EMIT - 1);
                    product_due.push_back(r);
                end
            end
            default: ;    // unused code: no effect
        endcase
    endtask

    task automatic queue_cmd(logic [1:0] op, int idx, logic [31:0] val);
        cmd_t c;
        c.operation     = op;
        c.element_index = 4'(idx);
        c.element_value = val;
        cmd_backlog.push_back(c);
        total_cmds++;
    endtask

    // Mix of float classes: plenty of ordinary magnitudes so sums mean
    // something, plus subnormals, zeros, infinities, NaNs and range edges.
    function automatic logic [31:0] pick_float();
        logic        s;
        logic [22:0] m;
        s = 1'($urandom_range(1));
        m = 23'($urandom);
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return {s, 8'($urandom_range(134, 120)), m};
            5:             return $urandom;
            6:             return {s, 8'h00, m};
            7:             return {s, 31'h0};
            8:             return $urandom_range(1) ? {s, 8'hFF, 23'h0} : {s, 8'hFF, m | 23'h1};
            default:       return $urandom_range(1) ? {s, 8'($urandom_range(10, 1)), m}
                                                    : {s, 8'($urandom_range(254, 245)), m};
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: a beat is taken at an edge with start high and busy low.
    // Sender idling is 12 % for the first third, 56 % for the second,
    // none for the rest.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            int idle_pct;
            if (beats_taken < total_cmds / 3)
                idle_pct = 12;
            else if (beats_taken < 2 * total_cmds / 3)
                idle_pct = 56;
            else
                idle_pct = 0;
            if (start && !busy)
            begin
                apply_command(command);
                beats_taken++;
            end
            if (!start || !busy)
            begin
                if (cmd_backlog.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    command <= cmd_backlog.pop_front();
                    start   <= 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor and watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || strobe)
                quiet_cyc <= 0;
            else
                quiet_cyc <= quiet_cyc + 1;

            if (strobe)
            begin
                if (product_due.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected product beat idx=%0d val=%h last=%b",
                                 result.result_index, result.result_value,
                                 result.last_result);
                end
                else
                begin
                    res_t want;
                    want = product_due.pop_front();
                    if (result.result_index !== want.result_index
                        || result.result_value !== want.result_value
                        || result.last_result !== want.last_result)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"product mismatch: exp idx=%0d val=%h last=%b, ",
                                      "got idx=%0d val=%h last=%b"},
                                     want.result_index, want.result_value, want.last_result,
                                     result.result_index, result.result_value,
                                     result.last_result);
                    end
                end
            end

            if (quiet_cyc >= STALL_MAX)
            begin
                $display("watchdog expired");
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial
    begin
        int n;
        for (int i = 0; i < 16; i++)
        begin
            left_mat[i]  = POS_ZERO;
            right_mat[i] = POS_ZERO;
        end

        // Directed: product of the cleared stores, then special values.
        queue_cmd(OP_COMPUTE, 0, 32'h0);
        // right row 0 all negative zero: its sums with no inf or NaN term must come out +0
        for (int j = 0; j < 4; j++)
            queue_cmd(OP_LOAD_RIGHT, j, 32'h8000_0000);
        queue_cmd(OP_LOAD_LEFT, 0, 32'h7F80_0000);    // inf * -0 gives NaN
        queue_cmd(OP_LOAD_LEFT, 4, 32'h7FA1_2345);    // NaN with payload
        queue_cmd(OP_LOAD_LEFT, 15, 32'h7F7F_FFFF);
        queue_cmd(OP_LOAD_LEFT, 5, 32'h0000_0001);
        queue_cmd(OP_LOAD_RIGHT, 5, 32'h3F80_0000);
        queue_cmd(OP_LOAD_RIGHT, 6, 32'hFF80_0000);
        queue_cmd(OP_LOAD_LEFT, 9, 32'h7F80_0000);    // inf * -inf gives -inf in row 1
        queue_cmd(2'd3, 15, 32'hFFFF_FFFF);           // unused code
        queue_cmd(OP_LOAD_RIGHT, 15, 32'h7F7F_FFFF);  // overflow to inf
        queue_cmd(OP_LOAD_LEFT, 14, 32'h0080_0000);
        queue_cmd(OP_LOAD_RIGHT, 12, 32'h0000_0001);
        queue_cmd(OP_COMPUTE, 0, 32'h0);

        // Random: mostly random loads over all sixteen indices, each to either matrix,
        // then a compute; the rest short bursts of noise including the unused code.
        n = 0;
        while (n < RAND_ITEMS)
        begin
            if ($urandom_range(99) < 70)
            begin
                for (int i = 0; i < 16; i++)
                begin
                    queue_cmd($urandom_range(1) ? OP_LOAD_LEFT : OP_LOAD_RIGHT, i,
                              pick_float());
                    queue_cmd($urandom_range(1) ? OP_LOAD_RIGHT : OP_LOAD_LEFT,
                              $urandom_range(15), pick_float());
                end
                queue_cmd(OP_COMPUTE, $urandom_range(15), $urandom);
                n += 33;
            end
            else
            begin
                repeat ($urandom_range(6, 1))
                begin
                    queue_cmd(2'($urandom_range(3)), $urandom_range(15),
                              $urandom_range(1) ? pick_float() : $urandom);
                    n++;
                end
                if ($urandom_range(1))
                begin
                    queue_cmd(OP_COMPUTE, $urandom_range(15), $urandom);
                    n++;
                end
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || start)
            @(posedge clk);
        while (product_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### sim.f
src/mfm_pkg.sv
src/mfm_fpu.sv
src/matrix4_float_multiply.sv
bench/tb_top.sv
